// ----- sv/hld_pkg.sv -----
// ----------------------------------------------------------------------------
// hld_pkg
// Types and constants shared by the hub label distance query block.
// ----------------------------------------------------------------------------
package hld_pkg;

    localparam int VERTEX_W = 10;
    localparam int SLOT_W   = 6;
    localparam int HUB_W    = 10;
    localparam int HDIST_W  = 31;
    localparam int DIST_W   = 32;

    // Request type codes.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Distance reported when the two lists share no hub.
    localparam logic [DIST_W-1:0] DIST_NONE = '1;

    typedef struct packed {
        logic                req_type;
        logic [VERTEX_W-1:0] vertex;
        logic [SLOT_W-1:0]   slot;
        logic [HUB_W-1:0]    hub;
        logic [HDIST_W-1:0]  hub_distance;
        logic                last_entry;
        logic [VERTEX_W-1:0] other_vertex;
    } req_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              found;
    } res_t;

    // One stored label entry.
    typedef struct packed {
        logic [HUB_W-1:0]   hub;
        logic [HDIST_W-1:0] hdist;
    } entry_t;

    // Status from the merge engine to the control.
    typedef struct packed {
        logic              done;
        logic              found;
        logic [DIST_W-1:0] distance;
    } merge_status_t;

endpackage

// ----- sv/hub_label_distance_query.sv -----
// ----------------------------------------------------------------------------
// hub_label_distance_query
// Hub label store with two-hop shortest distance queries.
// ----------------------------------------------------------------------------
// A beat on the request port is accepted when start is high and busy is low.
// A write beat (req_type = 0) stores one (hub, distance) entry at a slot of a
// vertex's label list; with last_entry set it also sets the list length to
// slot + 1. Writes with an out-of-range vertex or slot are dropped. A query
// beat (req_type = 1) merge-walks the label lists of vertex and other_vertex,
// one step per cycle, and delivers one result beat: the minimum summed 24.8
// distance over shared hubs with found = 1, or all ones with found = 0. A
// query keeps busy high through the load of the list heads and the merge
// walk; the walk reads one entry of each list per cycle through the two read
// ports of the entry memory. The result is shown on result for exactly one
// cycle with done high, and the receiver cannot stall it; busy is already low
// in that cycle, so the next beat may be accepted alongside. After reset the
// block runs a clearing pass over the length memory that keeps busy high
// until every length is cleared.
// ----------------------------------------------------------------------------
module hub_label_distance_query #(
    parameter int VERTICES    = 1024,
    parameter int LABEL_SLOTS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  hld_pkg::req_t request,
    output logic          done,
    output hld_pkg::res_t result
);

    import hld_pkg::*;

    localparam int LW    = $clog2(LABEL_SLOTS + 1);
    localparam int DEPTH = VERTICES * LABEL_SLOTS;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int VAW   = VERTICES > 1 ? $clog2(VERTICES) : 1;

    // Control states.
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOAD  = 2'd2;
    localparam logic [1:0] ST_WALK  = 2'd3;

    // Base address of a vertex's row in the entry memory.
    function automatic logic [AW-1:0] row_base(input logic [VERTEX_W-1:0] v);
        return AW'(32'(v) * LABEL_SLOTS);
    endfunction

    logic [1:0]          state_reg, state_next;
    logic [VAW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [VERTEX_W-1:0] va_reg, va_next, vb_reg, vb_next;
    logic                a_ok_reg, a_ok_next, b_ok_reg, b_ok_next;
    logic                done_reg, done_next;
    res_t                result_reg, result_next;

    logic                accept, wr_item, qry_item, vert_ok, slot_ok, other_ok;

    // Entry memory ports.
    logic                ent_we;
    logic [AW-1:0]       ent_waddr, ent_raddr_a, ent_raddr_b;
    entry_t              ent_wdata, ent_rdata_a, ent_rdata_b;

    // Length memory ports.
    logic                len_we;
    logic [VAW-1:0]      len_waddr, len_raddr_a, len_raddr_b;
    logic [LW-1:0]       len_wdata, len_rdata_a, len_rdata_b;

    // Merge engine hookup.
    logic                m_load, m_walk;
    logic [LW-1:0]       m_len_a, m_len_b;
    logic [LW:0]         rd_idx_a, rd_idx_b;
    merge_status_t       m_status;

    always_comb
    begin
        accept   = start && (state_reg == ST_IDLE);
        wr_item  = accept && (request.req_type == REQ_WRITE);
        qry_item = accept && (request.req_type == REQ_QUERY);
        vert_ok  = 32'(request.vertex) < VERTICES;
        other_ok = 32'(request.other_vertex) < VERTICES;
        slot_ok  = 32'(request.slot) < LABEL_SLOTS;

        // Entry writes come only from accepted write beats.
        ent_we          = wr_item && vert_ok && slot_ok;
        ent_waddr       = row_base(request.vertex) + AW'(request.slot);
        ent_wdata.hub   = request.hub;
        ent_wdata.hdist = request.hub_distance;

        // The clearing pass owns the length write port until it finishes.
        if (state_reg == ST_CLEAR)
        begin
            len_we    = 1'b1;
            len_waddr = clr_cnt_reg;
            len_wdata = '0;
        end
        else
        begin
            len_we    = wr_item && vert_ok && slot_ok && request.last_entry;
            len_waddr = VAW'(request.vertex);
            len_wdata = LW'(32'(request.slot) + 1);
        end
        len_raddr_a = VAW'(request.vertex);
        len_raddr_b = VAW'(request.other_vertex);

        // In idle the first entries are fetched; afterwards the engine
        // steers the reads to the entry after each head.
        if (state_reg == ST_IDLE)
        begin
            ent_raddr_a = row_base(request.vertex);
            ent_raddr_b = row_base(request.other_vertex);
        end
        else
        begin
            ent_raddr_a = row_base(va_reg) + AW'(rd_idx_a);
            ent_raddr_b = row_base(vb_reg) + AW'(rd_idx_b);
        end

        m_load  = state_reg == ST_LOAD;
        m_walk  = state_reg == ST_WALK;
        m_len_a = a_ok_reg ? len_rdata_a : '0;
        m_len_b = b_ok_reg ? len_rdata_b : '0;
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        va_next      = va_reg;
        vb_next      = vb_reg;
        a_ok_next    = a_ok_reg;
        b_ok_next    = b_ok_reg;
        done_next    = 1'b0;
        result_next  = result_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + VAW'(1);
                if (clr_cnt_reg == VAW'(VERTICES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (qry_item)
                begin
                    va_next    = request.vertex;
                    vb_next    = request.other_vertex;
                    a_ok_next  = vert_ok;
                    b_ok_next  = other_ok;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (m_status.done)
                begin
                    done_next            = 1'b1;
                    result_next.distance = m_status.distance;
                    result_next.found    = m_status.found;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            a_ok_reg    <= 1'b0;
            b_ok_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            a_ok_reg    <= a_ok_next;
            b_ok_reg    <= b_ok_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        va_reg     <= va_next;
        vb_reg     <= vb_next;
        result_reg <= result_next;
    end

    assign busy   = state_reg != ST_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

    hld_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .we      (ent_we),
        .waddr   (ent_waddr),
        .wdata   (ent_wdata),
        .raddr_a (ent_raddr_a),
        .raddr_b (ent_raddr_b),
        .rdata_a (ent_rdata_a),
        .rdata_b (ent_rdata_b)
    );

    hld_ram #(
        .WIDTH (LW),
        .DEPTH (VERTICES)
    ) u_len_ram (
        .clk     (clk),
        .we      (len_we),
        .waddr   (len_waddr),
        .wdata   (len_wdata),
        .raddr_a (len_raddr_a),
        .raddr_b (len_raddr_b),
        .rdata_a (len_rdata_a),
        .rdata_b (len_rdata_b)
    );

    hld_merge #(
        .LABEL_SLOTS (LABEL_SLOTS)
    ) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (m_load),
        .walk     (m_walk),
        .len_a    (m_len_a),
        .len_b    (m_len_b),
        .ent_a    (ent_rdata_a),
        .ent_b    (ent_rdata_b),
        .rd_idx_a (rd_idx_a),
        .rd_idx_b (rd_idx_b),
        .status   (m_status)
    );

`ifndef SYNTH
    // An accepted query always moves on to loading the list heads.
    a_query_loads: assert property (@(posedge clk) disable iff (!rst_n)
        qry_item |=> state_reg == ST_LOAD)
        else $error("accepted query did not enter the load state");

    // A result beat only follows the end of a merge walk.
    a_done_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) == ST_WALK)
        else $error("result strobe without a finished walk");

    // A result without a shared hub carries the all-ones distance.
    a_none_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !result_reg.found |-> result_reg.distance == DIST_NONE)
        else $error("no shared hub but distance is not all ones");

    // The entry memory is never written by a beat during the clearing pass.
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> busy && !ent_we)
        else $error("entry write during the clearing pass");
`endif

endmodule

// ----- sv/hld_ram.sv -----
// ----------------------------------------------------------------------------
// hld_ram
// Generic RAM: one write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module hld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic [WIDTH-1:0]                      rdata_a,
    output logic [WIDTH-1:0]                      rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- sv/hld_merge.sv -----
// ----------------------------------------------------------------------------
// hld_merge
// Merge-walk engine: holds the current head entry of each list and takes
// one step per cycle, keeping the minimum summed distance over shared hubs.
// ----------------------------------------------------------------------------
module hld_merge #(
    parameter int LABEL_SLOTS = 64
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    load,
    input  logic                                    walk,
    input  logic [$clog2(LABEL_SLOTS+1)-1:0]        len_a,
    input  logic [$clog2(LABEL_SLOTS+1)-1:0]        len_b,
    input  hld_pkg::entry_t                         ent_a,
    input  hld_pkg::entry_t                         ent_b,
    output logic [$clog2(LABEL_SLOTS+1):0]          rd_idx_a,
    output logic [$clog2(LABEL_SLOTS+1):0]          rd_idx_b,
    output hld_pkg::merge_status_t                  status
);

    import hld_pkg::*;

    localparam int LW = $clog2(LABEL_SLOTS + 1);

    logic [LW-1:0]     na_reg, na_next, nb_reg, nb_next;
    logic [LW-1:0]     i_reg, i_next, j_reg, j_next;
    entry_t            head_a_reg, head_a_next, head_b_reg, head_b_next;
    logic [DIST_W-1:0] best_reg, best_next;
    logic              found_reg, found_next;

    logic              active, hub_eq, hub_lt, adv_a, adv_b, take;
    logic [DIST_W-1:0] sum;

    always_comb
    begin
        active = (i_reg < na_reg) && (j_reg < nb_reg);
        hub_eq = head_a_reg.hub == head_b_reg.hub;
        hub_lt = head_a_reg.hub < head_b_reg.hub;
        sum    = DIST_W'(head_a_reg.hdist) + DIST_W'(head_b_reg.hdist);
        adv_a  = walk && active && (hub_eq || hub_lt);
        adv_b  = walk && active && !hub_lt;
        take   = walk && active && hub_eq && (!found_reg || (sum < best_reg));

        na_next     = na_reg;
        nb_next     = nb_reg;
        i_next      = i_reg + LW'(adv_a);
        j_next      = j_reg + LW'(adv_b);
        head_a_next = adv_a ? ent_a : head_a_reg;
        head_b_next = adv_b ? ent_b : head_b_reg;
        best_next   = take ? sum : best_reg;
        found_next  = found_reg || (walk && active && hub_eq);

        if (load)
        begin
            na_next     = len_a;
            nb_next     = len_b;
            i_next      = '0;
            j_next      = '0;
            head_a_next = ent_a;
            head_b_next = ent_b;
            best_next   = DIST_NONE;
            found_next  = 1'b0;
        end

        // The RAM is always fetching the entry after the head.
        rd_idx_a = {1'b0, i_next} + (LW+1)'(1);
        rd_idx_b = {1'b0, j_next} + (LW+1)'(1);

        status.done     = walk && !active;
        status.found    = found_reg;
        status.distance = best_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            na_reg    <= '0;
            nb_reg    <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            na_reg    <= na_next;
            nb_reg    <= nb_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_a_reg <= head_a_next;
        head_b_reg <= head_b_next;
        best_reg   <= best_next;
    end

endmodule

// ----- tb/tb_hub_label_distance_query.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hub_label_distance_query
// Self-checking testbench for the hub label distance query block.
// ----------------------------------------------------------------------------
// An initial block builds the whole request stream up front. It starts with a
// short directed set of beats and follows with random label lists and
// queries. While it builds the stream, it keeps a shadow of which label
// entries have been written. That way no query ever walks over an entry that
// was never written, because the block leaves those undefined.
//
// A clocked driver offers the pending beats on start/request and idles at
// random in two of three stretches. A clocked monitor checks every done beat.
// Every accepted beat goes into a label store that the testbench keeps for
// itself. Each accepted query merge-walks that store to get the distance it
// expects. The expected results queue up in order, and the monitor compares
// each result beat, field by field, against the oldest one.
// ----------------------------------------------------------------------------
module tb_hub_label_distance_query;
    import hld_pkg::*;

    localparam int VERTICES     = 1024;
    localparam int LABEL_SLOTS  = 64;
    localparam int RANDOM_BEATS = 500;
    // Drain time at the end of the run, longer than the longest query.
    localparam int DRAIN_CYCLES = 2 * LABEL_SLOTS + 16;
    localparam logic [HDIST_W-1:0] HDIST_MAX = '1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    req_t request = '0;
    logic done;
    res_t result;

    // Request beats still to be offered, built once at time zero.
    req_t pending_beats[$];
    int unsigned total_beats = 0;
    int unsigned launched = 0;

    // Label store as the testbench sees it, updated on every accepted beat.
    logic [HUB_W-1:0]   hub_mem  [VERTICES*LABEL_SLOTS];
    logic [HDIST_W-1:0] dist_mem [VERTICES*LABEL_SLOTS];
    int unsigned        len_mem  [VERTICES];

    // Query answers that have been predicted but not yet seen on done.
    res_t pending_distances[$];
    int unsigned mismatch_count = 0;

    // The stream builder keeps this shadow so that it only queries lists
    // whose every entry inside the length has been written.
    bit gen_filled [VERTICES*LABEL_SLOTS];
    int gen_len    [VERTICES];
    int vertex_pool[$];

    hub_label_distance_query #(
        .VERTICES    (VERTICES),
        .LABEL_SLOTS (LABEL_SLOTS)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Reset is held low at the start and then released for the rest of the run.
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // The merge walk over the two stored lists. It advances the side with
    // the smaller hub id, so lists whose hubs are out of order are handled
    // exactly as the hardware does. Shared hubs keep the smallest sum. The
    // sum of two 23.8 values is exact in 32 bits.
    function automatic res_t shortest_two_hop(input logic [VERTEX_W-1:0] va,
                                              input logic [VERTEX_W-1:0] vb);
        res_t              r;
        int unsigned       i;
        int unsigned       j;
        int unsigned       ia;
        int unsigned       ib;
        logic [DIST_W-1:0] sum;
        r.distance = DIST_NONE;
        r.found    = 1'b0;
        i = 0;
        j = 0;
        while (i < len_mem[va] && j < len_mem[vb])
        begin
            ia = va * LABEL_SLOTS + i;
            ib = vb * LABEL_SLOTS + j;
            if (hub_mem[ia] == hub_mem[ib])
            begin
                sum = {1'b0, dist_mem[ia]} + {1'b0, dist_mem[ib]};
                if (!r.found || sum < r.distance)
                    r.distance = sum;
                r.found = 1'b1;
                i++;
                j++;
            end
            else if (hub_mem[ia] < hub_mem[ib])
                i++;
            else
                j++;
        end
        return r;
    endfunction

    // Applies one accepted beat to the label store. A query also queues the
    // answer it should produce.
    task automatic commit_beat_to_labels(input req_t beat);
        int unsigned idx;
        if (beat.req_type == REQ_WRITE)
        begin
            // Every 10-bit vertex and 6-bit slot is in range, so no write is
            // dropped with the default sizes.
            if (beat.vertex < VERTICES && beat.slot < LABEL_SLOTS)
            begin
                idx = beat.vertex * LABEL_SLOTS + beat.slot;
                hub_mem[idx]  = beat.hub;
                dist_mem[idx] = beat.hub_distance;
                if (beat.last_entry)
                    len_mem[beat.vertex] = beat.slot + 1;
            end
        end
        else
            pending_distances.insert(pending_distances.size(),
                                     shortest_two_hop(beat.vertex, beat.other_vertex));
    endtask

    // ------------------------------------------------------------------------
    // Stream building
    // ------------------------------------------------------------------------

    function automatic logic [HDIST_W-1:0] rand_hub_distance();
        case ($urandom_range(3))
            0: return HDIST_W'($urandom_range(0, 1023));
            1: return HDIST_MAX - HDIST_W'($urandom_range(0, 255));
            default: return HDIST_W'($urandom);
        endcase
    endfunction

    function automatic bit list_ready(input int v);
        for (int s = 0; s < gen_len[v]; s++)
        begin
            if (!gen_filled[v * LABEL_SLOTS + s])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic push_write(input int v, input int s, input int hub,
                              input logic [HDIST_W-1:0] hdist, input bit last);
        req_t r;
        r.req_type     = REQ_WRITE;
        r.vertex       = VERTEX_W'(v);
        r.slot         = SLOT_W'(s);
        r.hub          = HUB_W'(hub);
        r.hub_distance = hdist;
        r.last_entry   = last;
        r.other_vertex = VERTEX_W'($urandom);
        pending_beats.insert(pending_beats.size(), r);
        gen_filled[v * LABEL_SLOTS + s] = 1'b1;
        if (last)
            gen_len[v] = s + 1;
    endtask

    // Fields that a query does not use are still randomized, so that their
    // bits toggle in both kinds of beat.
    task automatic push_query(input int va, input int vb);
        req_t r;
        r.req_type     = REQ_QUERY;
        r.vertex       = VERTEX_W'(va);
        r.slot         = SLOT_W'($urandom);
        r.hub          = HUB_W'($urandom);
        r.hub_distance = HDIST_W'($urandom);
        r.last_entry   = 1'($urandom);
        r.other_vertex = VERTEX_W'(vb);
        pending_beats.insert(pending_beats.size(), r);
    endtask

    function automatic void shuffle_ints(inout int q[$]);
        int k;
        int t;
        for (int n = q.size() - 1; n > 0; n--)
        begin
            k    = $urandom_range(0, n);
            t    = q[n];
            q[n] = q[k];
            q[k] = t;
        end
    endfunction

    // Writes a complete list of up to n entries. The hubs are ascending and
    // mostly packed into a narrow range, so that different lists share hubs.
    // Now and then the slots are written out of order, or the hubs are
    // shuffled so that they are no longer ascending.
    task automatic write_label_list(input int v, input int n);
        int hubs[$];
        int order[$];
        int h;
        h = ($urandom_range(3) == 0) ? $urandom_range(0, 960) : $urandom_range(0, 12);
        while (hubs.size() < n && h < VERTICES)
        begin
            hubs.insert(hubs.size(), h);
            h += 1 + $urandom_range(0, 2);
        end
        for (int s = 0; s < hubs.size(); s++)
            order.insert(order.size(), s);
        if ($urandom_range(9) == 0)
            shuffle_ints(hubs);
        if ($urandom_range(4) == 0)
            shuffle_ints(order);
        foreach (order[k])
            push_write(v, order[k], hubs[order[k]], rand_hub_distance(),
                       order[k] == hubs.size() - 1);
    endtask

    function automatic int pick_list_len();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return $urandom_range(1, 8);
        if (r < 95)
            return $urandom_range(9, 24);
        return LABEL_SLOTS;
    endfunction

    function automatic int pick_pool_vertex();
        return vertex_pool[$urandom_range(0, vertex_pool.size() - 1)];
    endfunction

    // A query always goes to a list that is fully written. If a pool vertex
    // was left half written by noise, it first gets a fresh list.
    task automatic query_pool_pair();
        int va;
        int vb;
        va = pick_pool_vertex();
        vb = ($urandom_range(9) == 0) ? va : pick_pool_vertex();
        if (!list_ready(va))
            write_label_list(va, pick_list_len());
        if (!list_ready(vb))
            write_label_list(vb, pick_list_len());
        push_query(va, vb);
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers the next pending beat when the port is free and keeps
    // start and request steady while busy holds a beat off.
    // ------------------------------------------------------------------------

    // The sender idles 26 % of the time in the first third of the stream,
    // 64 % in the second third, and never in the last third.
    function automatic int unsigned sender_idle_pct();
        if (launched * 3 < total_beats)
            return 26;
        if (launched * 3 < 2 * total_beats)
            return 64;
        return 0;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                commit_beat_to_labels(request);
            if (!start || !busy)
            begin
                if (pending_beats.size() > 0 && $urandom_range(99) >= sender_idle_pct())
                begin
                    request <= pending_beats.pop_front();
                    start   <= 1'b1;
                    launched++;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every done beat must match the oldest predicted answer.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && done)
        begin
            if (pending_distances.size() == 0)
            begin
                $display("%0t: result with no query waiting: expected none, actual %h/%b",
                         $time, result.distance, result.found);
                mismatch_count++;
            end
            else
            begin
                want = pending_distances.pop_front();
                if (result.distance !== want.distance)
                begin
                    $display("%0t: distance mismatch: expected %h, actual %h",
                             $time, want.distance, result.distance);
                    mismatch_count++;
                end
                if (result.found !== want.found)
                begin
                    $display("%0t: found mismatch: expected %b, actual %b",
                             $time, want.found, result.found);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned directed_end;
        int          long_lists;
        int          pick;
        int          va;
        int          vb;

        // Directed part. The first query runs on empty lists. Next come the
        // extreme hub ids and distances, with the largest sum that is still
        // found. A list then grows without last_entry, and its length only
        // moves once last_entry is set. After that come a tied minimum, a
        // vertex queried against itself, hubs that are not ascending, a
        // query against an empty list, a write to the top slot and a list
        // that shrinks.
        push_query(0, VERTICES - 1);
        push_write(0, 0, 0, HDIST_MAX, 1'b0);
        push_write(0, 1, VERTICES - 1, '0, 1'b1);
        push_write(VERTICES - 1, 0, 0, HDIST_MAX, 1'b1);
        push_query(0, VERTICES - 1);
        push_write(VERTICES - 1, 1, VERTICES - 1, HDIST_MAX, 1'b0);
        push_query(0, VERTICES - 1);
        push_write(VERTICES - 1, 1, VERTICES - 1, HDIST_W'(5), 1'b1);
        push_query(VERTICES - 1, 0);
        push_write(2, 0, 0, '0, 1'b0);
        push_write(2, 1, VERTICES - 1, HDIST_MAX, 1'b1);
        push_query(2, 0);
        push_query(0, 0);
        push_write(3, 0, VERTICES - 1, HDIST_W'(1), 1'b0);
        push_write(3, 1, 0, HDIST_W'(1), 1'b1);
        push_query(3, 0);
        push_query(3, 1);
        push_write(4, LABEL_SLOTS - 1, 512, HDIST_MAX, 1'b0);
        push_write(0, 0, 0, HDIST_W'(3), 1'b1);
        push_query(0, 2);
        push_query(1, 1);
        directed_end = pending_beats.size();

        vertex_pool.insert(vertex_pool.size(), 0);
        vertex_pool.insert(vertex_pool.size(), VERTICES - 1);
        for (int k = 0; k < 14; k++)
            vertex_pool.insert(vertex_pool.size(), $urandom_range(1, VERTICES - 2));

        // Random part: mostly whole lists followed by queries over them,
        // plus stray writes and stray queries as noise. The first few lists
        // are asked for at full length, so that every slot is written unless the hubs
        // run past the top id, and the longest merge walks come up early.
        long_lists = 0;
        while (pending_beats.size() < directed_end + RANDOM_BEATS)
        begin
            pick = $urandom_range(99);
            if (long_lists < 3)
            begin
                write_label_list(pick_pool_vertex(), LABEL_SLOTS);
                long_lists++;
            end
            else if (pick < 30)
                write_label_list(pick_pool_vertex(), pick_list_len());
            else if (pick < 85)
                query_pool_pair();
            else if (pick < 95)
                push_write($urandom_range(0, VERTICES - 1), $urandom_range(0, LABEL_SLOTS - 1),
                           $urandom_range(0, VERTICES - 1), rand_hub_distance(),
                           1'($urandom));
            else
            begin
                va = $urandom_range(0, VERTICES - 1);
                vb = $urandom_range(0, VERTICES - 1);
                if (list_ready(va) && list_ready(vb))
                    push_query(va, vb);
                else
                    query_pool_pair();
            end
        end
        total_beats = pending_beats.size();

        // Once the queue is empty and start has dropped, every beat has been
        // accepted. Then wait for the answers still in flight, and give the
        // block a little longer in case a stray result shows up.
        @(posedge clk);
        while (pending_beats.size() != 0 || start)
            @(posedge clk);
        while (pending_distances.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_distances.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/hld_pkg.sv
sv/hld_ram.sv
sv/hld_merge.sv
sv/hub_label_distance_query.sv
tb/tb_hub_label_distance_query.sv
